// ----- hdl/ray_box_nearest_pick_core_macros.svh -----
// Assertion macros for the ray box pick checker.
`ifndef RAY_BOX_NEAREST_PICK_CORE_MACROS_SVH
`define RAY_BOX_NEAREST_PICK_CORE_MACROS_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define RBNP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rbnp: same-cycle check failed");

// Next-cycle implication, clocked on clk, off during reset.
`define RBNP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rbnp: next-cycle check failed");

`endif

// ----- hdl/rbnp_pkg.sv -----
// Types and constants for the ray box nearest pick core.
package rbnp_pkg;

    localparam int COORD_W    = 32;
    localparam int EXT_W      = 30;
    localparam int DIR_W      = 18;
    localparam int BOUND_W    = 33;
    localparam int DIFF_W     = 34;
    localparam int FRAC_W     = 16;
    localparam int NUM_W      = 49;
    localparam int T_W        = 50;
    localparam int RADIX_BITS = 7;
    localparam int DIV_STEPS  = NUM_W / RADIX_BITS;
    localparam int STEP_W     = 3;
    localparam int DIST_W     = 32;
    localparam int INDEX_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int IN_DATA_W  = 192;
    localparam int OUT_DATA_W = 48;

    localparam logic signed [T_W-1:0]   T_MAX       = {1'b0, {(T_W-1){1'b1}}};
    localparam logic signed [DIR_W-1:0] DIR_Z_RESET = 18'sd65536;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORIGIN_X = 3'd0,
        REG_ORIGIN_Y = 3'd1,
        REG_ORIGIN_Z = 3'd2,
        REG_DIR_X    = 3'd3,
        REG_DIR_Y    = 3'd4,
        REG_DIR_Z    = 3'd5
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_DIV,
        ST_SIGN,
        ST_ORDER,
        ST_MERGE,
        ST_FINAL,
        ST_EMIT
    } state_t;

endpackage

// ----- hdl/ray_box_nearest_pick_core.sv -----
// Nearest ray/box pick: slab test per box through one shared radix-128 divider.
//
// Setup: write the ray origin (regs 0..2, signed Q16.16) and the direction
// (regs 3..5, 18 bit signed Q2.16) on the cfg channel while the core is idle.
// Boxes arrive one word at a time on s_axis; s_axis_tlast marks the last box
// of a pick. After that box, one word leaves on m_axis: tuser is the hit flag,
// tdata carries the winning index and its entry distance (zero on no hit).
// Each nonzero direction axis runs two divisions plus setup, sign and
// ordering steps; a zero axis only checks the origin against its slab.
// A box thus keeps s_axis_tready low until its test is done (divider bound),
// a last box also through the emit step plus any wait for the output slot.
// Boxes past the index limit skip the test and go straight to the final step.
// m_axis_tvalid is registered and rises after the emit step of the last box.
// The result sits in an output register; while m_axis is stalled the core
// keeps taking boxes, and only the next pick's result waits for the slot.
// Reset clears the pick state and loads origin 0 and direction +z.
module ray_box_nearest_pick_core #(
    parameter int MAX_BOXES = 65536
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [rbnp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rbnp_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // center_x, center_y, center_z, half_extent_x, _y, _z, zero pad
    input  logic [rbnp_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    input  logic                               s_axis_tlast,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // picked_index, picked_distance
    output logic [rbnp_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // pick_valid
    output logic                               m_axis_tuser
);

    localparam int IDX_LIMIT = (MAX_BOXES < 65536) ? MAX_BOXES : 65536;
    localparam int BC_W      = $clog2(IDX_LIMIT + 1);

    localparam int CW = rbnp_pkg::COORD_W;
    localparam int EW = rbnp_pkg::EXT_W;
    localparam int DW = rbnp_pkg::DIR_W;
    localparam int TW = rbnp_pkg::T_W;
    localparam int NW = rbnp_pkg::NUM_W;

    rbnp_pkg::state_t state_reg, state_next;

    logic signed [CW-1:0] origin_reg [3];
    logic signed [CW-1:0] origin_next [3];
    logic signed [DW-1:0] dir_reg [3];
    logic signed [DW-1:0] dir_next [3];

    logic signed [CW-1:0] center_reg [3];
    logic signed [CW-1:0] center_next [3];
    logic [EW-1:0]        ext_reg [3];
    logic [EW-1:0]        ext_next [3];
    logic                 last_reg, last_next;

    logic [1:0]           axis_reg, axis_next;
    logic                 side_reg, side_next;
    logic                 miss_reg, miss_next;
    logic signed [TW-1:0] near_reg, near_next;
    logic signed [TW-1:0] far_reg, far_next;
    logic signed [TW-1:0] tlo_reg, tlo_next;
    logic signed [TW-1:0] thi_reg, thi_next;
    logic signed [TW-1:0] ent_reg, ent_next;
    logic signed [TW-1:0] exit_reg, exit_next;

    logic [NW-1:0]                  num_reg, num_next;
    logic [DW-1:0]                  rem_reg, rem_next;
    logic [DW-1:0]                  dvs_reg, dvs_next;
    logic                           neg_reg, neg_next;
    logic [rbnp_pkg::STEP_W-1:0]    step_reg, step_next;

    logic [rbnp_pkg::DIST_W-1:0]    best_dist_reg, best_dist_next;
    logic [rbnp_pkg::INDEX_W-1:0]   best_idx_reg, best_idx_next;
    logic                           any_hit_reg, any_hit_next;
    logic [BC_W-1:0]                box_count_reg, box_count_next;

    logic                           out_valid_reg, out_valid_next;
    logic                           out_hit_reg, out_hit_next;
    logic [rbnp_pkg::OUT_DATA_W-1:0] out_data_reg, out_data_next;

    logic signed [CW-1:0]      c_sel, o_sel;
    logic [EW-1:0]             e_sel;
    logic signed [DW-1:0]      d_sel;
    logic signed [rbnp_pkg::BOUND_W-1:0] lo_b, hi_b, bound;
    logic signed [rbnp_pkg::DIFF_W-1:0]  diff, diff_abs, o_ext, lo_ext, hi_ext;
    logic signed [DW-1:0]      d_abs;
    logic [DW:0]               r;
    logic [NW-1:0]             n;
    logic signed [TW-1:0]      q_abs, t_val;
    logic                      tested, hit;
    logic [rbnp_pkg::DIST_W-1:0] hit_dist;
    logic                      s_take;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == rbnp_pkg::ST_IDLE);
    assign s_take        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_hit_reg;

    always_comb
    begin
        state_next     = state_reg;
        origin_next    = origin_reg;
        dir_next       = dir_reg;
        center_next    = center_reg;
        ext_next       = ext_reg;
        last_next      = last_reg;
        axis_next      = axis_reg;
        side_next      = side_reg;
        miss_next      = miss_reg;
        near_next      = near_reg;
        far_next       = far_reg;
        tlo_next       = tlo_reg;
        thi_next       = thi_reg;
        ent_next       = ent_reg;
        exit_next      = exit_reg;
        num_next       = num_reg;
        rem_next       = rem_reg;
        dvs_next       = dvs_reg;
        neg_next       = neg_reg;
        step_next      = step_reg;
        best_dist_next = best_dist_reg;
        best_idx_next  = best_idx_reg;
        any_hit_next   = any_hit_reg;
        box_count_next = box_count_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_hit_next   = out_hit_reg;
        out_data_next  = out_data_reg;

        // per-axis operands
        c_sel  = center_reg[axis_reg];
        e_sel  = ext_reg[axis_reg];
        o_sel  = origin_reg[axis_reg];
        d_sel  = dir_reg[axis_reg];
        lo_b   = $signed({c_sel[CW-1], c_sel}) - $signed({3'b000, e_sel});
        hi_b   = $signed({c_sel[CW-1], c_sel}) + $signed({3'b000, e_sel});
        bound  = side_reg ? hi_b : lo_b;
        o_ext  = $signed({{2{o_sel[CW-1]}}, o_sel});
        lo_ext = $signed({lo_b[rbnp_pkg::BOUND_W-1], lo_b});
        hi_ext = $signed({hi_b[rbnp_pkg::BOUND_W-1], hi_b});
        diff   = $signed({bound[rbnp_pkg::BOUND_W-1], bound}) - o_ext;
        diff_abs = diff[rbnp_pkg::DIFF_W-1] ? -diff : diff;
        d_abs  = d_sel[DW-1] ? -d_sel : d_sel;

        // radix-128 restoring divide step
        r = {1'b0, rem_reg};
        n = num_reg;
        for (int i = 0; i < rbnp_pkg::RADIX_BITS; i++)
        begin
            r = {r[DW-1:0], n[NW-1]};
            n = {n[NW-2:0], 1'b0};
            if (r >= {1'b0, dvs_reg})
            begin
                r    = r - {1'b0, dvs_reg};
                n[0] = 1'b1;
            end
        end

        q_abs = $signed({1'b0, num_reg});
        t_val = neg_reg ? -q_abs : q_abs;

        tested   = (box_count_reg < BC_W'(IDX_LIMIT));
        hit      = !miss_reg && (near_reg <= far_reg);
        hit_dist = (|near_reg[TW-1:rbnp_pkg::DIST_W]) ? '1 : near_reg[rbnp_pkg::DIST_W-1:0];

        if (cfg_valid)
        begin
            case (rbnp_pkg::cfg_reg_t'(cfg_index))
                rbnp_pkg::REG_ORIGIN_X: origin_next[0] = $signed(cfg_data);
                rbnp_pkg::REG_ORIGIN_Y: origin_next[1] = $signed(cfg_data);
                rbnp_pkg::REG_ORIGIN_Z: origin_next[2] = $signed(cfg_data);
                rbnp_pkg::REG_DIR_X:    dir_next[0]    = $signed(cfg_data[DW-1:0]);
                rbnp_pkg::REG_DIR_Y:    dir_next[1]    = $signed(cfg_data[DW-1:0]);
                rbnp_pkg::REG_DIR_Z:    dir_next[2]    = $signed(cfg_data[DW-1:0]);
                default: ;
            endcase
        end

        case (state_reg)
            rbnp_pkg::ST_IDLE:
            begin
                if (s_take)
                begin
                    center_next[0] = $signed(s_axis_tdata[31:0]);
                    center_next[1] = $signed(s_axis_tdata[63:32]);
                    center_next[2] = $signed(s_axis_tdata[95:64]);
                    ext_next[0]    = s_axis_tdata[125:96];
                    ext_next[1]    = s_axis_tdata[155:126];
                    ext_next[2]    = s_axis_tdata[185:156];
                    last_next      = s_axis_tlast;
                    axis_next      = 2'd0;
                    side_next      = 1'b0;
                    miss_next      = 1'b0;
                    near_next      = '0;
                    far_next       = rbnp_pkg::T_MAX;
                    state_next     = tested ? rbnp_pkg::ST_SETUP : rbnp_pkg::ST_FINAL;
                end
            end
            rbnp_pkg::ST_SETUP:
            begin
                if (miss_reg)
                begin
                    state_next = rbnp_pkg::ST_FINAL;
                end
                else if (d_sel == '0)
                begin
                    if ((o_ext < lo_ext) || (o_ext > hi_ext))
                        miss_next = 1'b1;
                    axis_next  = axis_reg + 2'd1;
                    state_next = (axis_reg == 2'd2) ? rbnp_pkg::ST_FINAL : rbnp_pkg::ST_SETUP;
                end
                else
                begin
                    num_next   = {diff_abs[32:0], {rbnp_pkg::FRAC_W{1'b0}}};
                    rem_next   = '0;
                    dvs_next   = d_abs;
                    neg_next   = diff[rbnp_pkg::DIFF_W-1] ^ d_sel[DW-1];
                    step_next  = '0;
                    state_next = rbnp_pkg::ST_DIV;
                end
            end
            rbnp_pkg::ST_DIV:
            begin
                num_next  = n;
                rem_next  = r[DW-1:0];
                step_next = step_reg + 1'b1;
                if (step_reg == rbnp_pkg::STEP_W'(rbnp_pkg::DIV_STEPS - 1))
                    state_next = rbnp_pkg::ST_SIGN;
            end
            rbnp_pkg::ST_SIGN:
            begin
                if (!side_reg)
                begin
                    tlo_next   = t_val;
                    side_next  = 1'b1;
                    state_next = rbnp_pkg::ST_SETUP;
                end
                else
                begin
                    thi_next   = t_val;
                    state_next = rbnp_pkg::ST_ORDER;
                end
            end
            rbnp_pkg::ST_ORDER:
            begin
                if (tlo_reg > thi_reg)
                begin
                    ent_next  = thi_reg;
                    exit_next = tlo_reg;
                end
                else
                begin
                    ent_next  = tlo_reg;
                    exit_next = thi_reg;
                end
                state_next = rbnp_pkg::ST_MERGE;
            end
            rbnp_pkg::ST_MERGE:
            begin
                if (ent_reg > near_reg)
                    near_next = ent_reg;
                if (exit_reg < far_reg)
                    far_next = exit_reg;
                side_next  = 1'b0;
                axis_next  = axis_reg + 2'd1;
                state_next = (axis_reg == 2'd2) ? rbnp_pkg::ST_FINAL : rbnp_pkg::ST_SETUP;
            end
            rbnp_pkg::ST_FINAL:
            begin
                if (tested)
                begin
                    if (hit && (!any_hit_reg || (hit_dist < best_dist_reg)))
                    begin
                        any_hit_next   = 1'b1;
                        best_dist_next = hit_dist;
                        best_idx_next  = rbnp_pkg::INDEX_W'(box_count_reg);
                    end
                    box_count_next = box_count_reg + 1'b1;
                end
                state_next = last_reg ? rbnp_pkg::ST_EMIT : rbnp_pkg::ST_IDLE;
            end
            rbnp_pkg::ST_EMIT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_hit_next   = any_hit_reg;
                    out_data_next  = any_hit_reg ? {best_dist_reg, best_idx_reg} : '0;
                    best_dist_next = '1;
                    best_idx_next  = '0;
                    any_hit_next   = 1'b0;
                    box_count_next = '0;
                    state_next     = rbnp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rbnp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rbnp_pkg::ST_IDLE;
            origin_reg[0] <= '0;
            origin_reg[1] <= '0;
            origin_reg[2] <= '0;
            dir_reg[0]    <= '0;
            dir_reg[1]    <= '0;
            dir_reg[2]    <= rbnp_pkg::DIR_Z_RESET;
            best_dist_reg <= '1;
            best_idx_reg  <= '0;
            any_hit_reg   <= 1'b0;
            box_count_reg <= '0;
            out_valid_reg <= 1'b0;
            axis_reg      <= '0;
            side_reg      <= 1'b0;
            step_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            origin_reg    <= origin_next;
            dir_reg       <= dir_next;
            best_dist_reg <= best_dist_next;
            best_idx_reg  <= best_idx_next;
            any_hit_reg   <= any_hit_next;
            box_count_reg <= box_count_next;
            out_valid_reg <= out_valid_next;
            axis_reg      <= axis_next;
            side_reg      <= side_next;
            step_reg      <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        center_reg   <= center_next;
        ext_reg      <= ext_next;
        last_reg     <= last_next;
        miss_reg     <= miss_next;
        near_reg     <= near_next;
        far_reg      <= far_next;
        tlo_reg      <= tlo_next;
        thi_reg      <= thi_next;
        ent_reg      <= ent_next;
        exit_reg     <= exit_next;
        num_reg      <= num_next;
        rem_reg      <= rem_next;
        dvs_reg      <= dvs_next;
        neg_reg      <= neg_next;
        out_hit_reg  <= out_hit_next;
        out_data_reg <= out_data_next;
    end

endmodule

// ----- hdl/rbnp_checker.sv -----
// Port-level checks for the ray box nearest pick core, bound into the core module.
`include "ray_box_nearest_pick_core_macros.svh"

module rbnp_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [rbnp_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input logic                             m_axis_tuser
);

    // stalled result word holds
    `RBNP_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // a miss carries an all-zero word
    `RBNP_ASSERT_NOW(a_miss_zero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == '0)

    // one box at a time
    `RBNP_ASSERT_NEXT(a_busy_after_take, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // no result word right after a box is taken
    `RBNP_ASSERT_NEXT(a_no_instant_result, s_axis_tvalid && s_axis_tready,
        !$rose(m_axis_tvalid))

endmodule

bind ray_box_nearest_pick_core rbnp_checker u_rbnp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ----- tb/sv/tb_ray_box_nearest_pick_core.sv -----
// Self-checking testbench for the ray box nearest pick core: directed and random box streams.
module tb_ray_box_nearest_pick_core;

    localparam int     BOX_LIMIT    = 40;
    localparam int     BOX_TARGET   = 1600;
    localparam int     PHASE_BOXES  = 100;
    localparam int     DRAIN_CYCLES = 80;
    localparam int     HOLD_CYCLES  = 2000;
    localparam longint RUN_LIMIT    = 64'd10_000_000;
    localparam longint DIST_SAT     = 64'sd4294967295;
    localparam longint FAR_START    = 64'sh7FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        bit              last;
        bit [2:0][29:0]  half;
        bit [2:0][31:0]  center;
    } box_t;

    typedef struct packed {
        bit        hit;
        bit [15:0] index;
        bit [31:0] distance;
    } pick_t;

    class pick_scoreboard;
        longint      ray_origin [3];
        longint      ray_dir [3];
        bit [31:0]   best_dist;
        bit [15:0]   best_idx;
        bit          any_hit;
        int unsigned box_count;
        int unsigned index_limit;
        pick_t       pending_picks [$];
        int          errors;
        int          picks_checked;
        int          hits_checked;

        function new(int unsigned limit);
            index_limit = (limit < 65536) ? limit : 65536;
            ray_origin  = '{0, 0, 0};
            ray_dir     = '{0, 0, 65536};
            errors        = 0;
            picks_checked = 0;
            hits_checked  = 0;
            clear_pick();
        endfunction

        function void clear_pick();
            best_dist = '1;
            best_idx  = '0;
            any_hit   = 1'b0;
            box_count = 0;
        endfunction

        function void write_reg(rbnp_pkg::cfg_reg_t idx, bit [31:0] value);
            case (idx)
                rbnp_pkg::REG_ORIGIN_X: ray_origin[0] = longint'($signed(value));
                rbnp_pkg::REG_ORIGIN_Y: ray_origin[1] = longint'($signed(value));
                rbnp_pkg::REG_ORIGIN_Z: ray_origin[2] = longint'($signed(value));
                rbnp_pkg::REG_DIR_X:    ray_dir[0]    = longint'($signed(value[17:0]));
                rbnp_pkg::REG_DIR_Y:    ray_dir[1]    = longint'($signed(value[17:0]));
                rbnp_pkg::REG_DIR_Z:    ray_dir[2]    = longint'($signed(value[17:0]));
                default: ;
            endcase
        endfunction

        // slab test; entry distance clamped at zero
        function bit slab_entry(box_t b, output longint entry);
            longint near_t, far_t, c, e, lo, hi, o, d, t1, t2, s;
            near_t = 0;
            far_t  = FAR_START;
            entry  = 0;
            for (int a = 0; a < 3; a++)
            begin
                c  = longint'($signed(b.center[a]));
                e  = longint'(b.half[a]);
                lo = c - e;
                hi = c + e;
                o  = ray_origin[a];
                d  = ray_dir[a];
                if (d == 0)
                begin
                    if (o < lo || o > hi)
                        return 1'b0;
                    continue;
                end
                t1 = ((lo - o) * 65536) / d;
                t2 = ((hi - o) * 65536) / d;
                if (t1 > t2)
                begin
                    s  = t1;
                    t1 = t2;
                    t2 = s;
                end
                if (t1 > near_t)
                    near_t = t1;
                if (t2 < far_t)
                    far_t = t2;
                if (near_t > far_t)
                    return 1'b0;
            end
            entry = near_t;
            return 1'b1;
        endfunction

        function void note_box(box_t b);
            longint    t;
            bit [31:0] hit_dist;
            pick_t     want;
            if (box_count < index_limit)
            begin
                if (slab_entry(b, t))
                begin
                    hit_dist = (t > DIST_SAT) ? 32'hFFFF_FFFF : 32'(t);
                    if (!any_hit || hit_dist < best_dist)
                    begin
                        any_hit   = 1'b1;
                        best_dist = hit_dist;
                        best_idx  = 16'(box_count);
                    end
                end
                box_count++;
            end
            if (b.last)
            begin
                want.hit      = any_hit;
                want.index    = any_hit ? best_idx : 16'd0;
                want.distance = any_hit ? best_dist : 32'd0;
                pending_picks.push_back(want);
                clear_pick();
            end
        endfunction

        task report_mismatch(string what, longint got, longint want);
            $display("mismatch on %s: got %0h, want %0h", what, got, want);
            errors++;
        endtask

        task check_pick(bit hit, bit [15:0] index, bit [31:0] distance);
            pick_t want;
            if (pending_picks.size() == 0)
            begin
                report_mismatch("unexpected pick word", longint'(index), 0);
                return;
            end
            want = pending_picks.pop_front();
            picks_checked++;
            if (hit)
                hits_checked++;
            if (hit != want.hit)
                report_mismatch("pick_valid", longint'(hit), longint'(want.hit));
            if (index != want.index)
                report_mismatch("picked_index", longint'(index), longint'(want.index));
            if (distance != want.distance)
                report_mismatch("picked_distance", longint'(distance), longint'(want.distance));
        endtask
    endclass

    logic                            clk           = 1'b0;
    logic                            rst_n         = 1'b0;
    logic                            cfg_valid     = 1'b0;
    logic                            cfg_ready;
    logic [rbnp_pkg::CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [rbnp_pkg::CFG_DATA_W-1:0] cfg_data      = '0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [rbnp_pkg::IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                            s_axis_tlast  = 1'b0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [rbnp_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic                            m_axis_tuser;

    pick_scoreboard sb = new(BOX_LIMIT);

    int send_idle_pct = 10;
    int recv_idle_pct = 56;
    bit rx_stall      = 1'b0;
    int boxes_sent    = 0;
    int ray_settings  = 0;
    int long_picks    = 0;

    ray_box_nearest_pick_core #(
        .MAX_BOXES(BOX_LIMIT)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    always #5 clk = ~clk;

    // result side: check accepted words, then pick tready for the next cycle
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_pick(m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[47:16]);
        m_axis_tready <= rst_n && !rx_stall && ($urandom_range(99) >= recv_idle_pct);
    end

    task write_ray_reg(rbnp_pkg::cfg_reg_t idx, bit [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_reg(idx, value);
    endtask

    task load_ray(int ox, int oy, int oz, int dx, int dy, int dz);
        write_ray_reg(rbnp_pkg::REG_ORIGIN_X, ox);
        write_ray_reg(rbnp_pkg::REG_ORIGIN_Y, oy);
        write_ray_reg(rbnp_pkg::REG_ORIGIN_Z, oz);
        write_ray_reg(rbnp_pkg::REG_DIR_X, dx);
        write_ray_reg(rbnp_pkg::REG_DIR_Y, dy);
        write_ray_reg(rbnp_pkg::REG_DIR_Z, dz);
        cfg_valid <= 1'b0;
        ray_settings++;
    endtask

    task send_box(box_t b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, b.half, b.center};
        s_axis_tlast  <= b.last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_box(b);
        boxes_sent++;
    endtask

    task wait_picks_done();
        s_axis_tvalid <= 1'b0;
        while (sb.pending_picks.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic box_t make_box(int cx, int cy, int cz, int ex, int ey, int ez, bit last);
        box_t b;
        b.center = {32'(cz), 32'(cy), 32'(cx)};
        b.half   = {30'(ez), 30'(ey), 30'(ex)};
        b.last   = last;
        return b;
    endfunction

    // mostly boxes placed along the current ray, plus repeats, origin boxes and noise
    function automatic box_t random_box(box_t prev);
        box_t        b;
        int unsigned kind, span, miss_axis;
        longint      t, p, ext, jit;
        kind      = $urandom_range(99);
        miss_axis = $urandom_range(2);
        b         = prev;
        b.last    = 1'b0;
        if (kind < 10)
            return b;
        if (kind < 25)
        begin
            b.center = {$urandom(), $urandom(), $urandom()};
            b.half   = {30'($urandom()), 30'($urandom()), 30'($urandom())};
            return b;
        end
        span = 32'd1 << $urandom_range(8, 28);
        t    = longint'($urandom_range(0, span - 1));
        for (int a = 0; a < 3; a++)
        begin
            if (kind < 40)
            begin
                p   = sb.ray_origin[a];
                ext = longint'($urandom_range(32'd1 << 16, 32'd1 << 28));
            end
            else
            begin
                p   = sb.ray_origin[a] + ((sb.ray_dir[a] * t) >>> 16);
                ext = longint'($urandom_range(0, 32'd1 << $urandom_range(4, 24)));
            end
            jit = longint'($urandom_range(0, 32'(ext))) - ext / 2;
            if (kind >= 85 && a == int'(miss_axis))
                jit = jit + ext + longint'($urandom_range(1, 4096));
            b.center[a] = 32'(p + jit);
            b.half[a]   = 30'(ext);
        end
        return b;
    endfunction

    function automatic int pick_origin(bit extreme);
        int unsigned r;
        r = $urandom_range(3);
        if (extreme)
            case (r)
                0: return 32'h8000_0000;
                1: return 32'h7FFF_FFFF;
                2: return 0;
                default: return int'($urandom());
            endcase
        if (r == 0)
            return int'($urandom());
        return int'($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000;
    endfunction

    function automatic int pick_dir(int style);
        int unsigned r;
        r = $urandom_range(2);
        case (style)
            0: return (r == 0) ? 0 : ((r == 1) ? 65536 : -65536);
            1: return int'($urandom_range(0, 131072)) - 65536;
            2: return int'($urandom_range(0, 262143)) - 131072;
            default: return (r == 0) ? 0 : int'($urandom_range(0, 131072)) - 65536;
        endcase
    endfunction

    initial
    begin
        box_t b, prev;
        int   n, phase_no, phase_count;
        bit   pressed;
        pressed  = 1'b0;
        phase_no = 0;
        prev     = make_box(0, 0, 0, 0, 0, 0, 1'b0);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ray left at reset: origin zero, looking down +z
        send_box(make_box(0, 0, 0, 0, 0, 0, 1'b1));
        send_box(make_box(0, 0, 10 << 16, 1 << 16, 1 << 16, 1 << 16, 1'b0));
        send_box(make_box(0, 0, 5 << 16, 1 << 16, 1 << 16, 1 << 16, 1'b0));
        send_box(make_box(0, 0, 5 << 16, 1 << 16, 1 << 16, 1 << 16, 1'b1));
        send_box(make_box(0, 0, -(10 << 16), 1 << 16, 1 << 16, 1 << 16, 1'b1));
        send_box(make_box(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                          32'h3FFF_FFFF, 32'h3FFF_FFFF, 32'h3FFF_FFFF, 1'b0));
        send_box(make_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                          32'h3FFF_FFFF, 32'h3FFF_FFFF, 32'h3FFF_FFFF, 1'b0));
        send_box(make_box(0, 0, 0, 32'h3FFF_FFFF, 32'h3FFF_FFFF, 32'h3FFF_FFFF, 1'b1));
        wait_picks_done();

        // tiny z step from the far corner: saturated distances and ties
        load_ray(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 1);
        send_box(make_box(32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 5, 1'b0));
        send_box(make_box(32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 5, 1'b0));
        send_box(make_box(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0010, 0, 0, 16, 1'b1));
        send_box(make_box(32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 5, 1'b1));
        wait_picks_done();

        // large directions, up to the ends of the 18-bit signed range
        load_ray(0, 0, 0, -65536, 131071, -131072);
        for (int k = 0; k < 4; k++)
        begin
            b      = random_box(prev);
            b.last = (k == 3);
            send_box(b);
            prev   = b;
        end
        wait_picks_done();

        while (boxes_sent < BOX_TARGET)
        begin
            if (boxes_sent < BOX_TARGET / 3)
            begin
                send_idle_pct = 10;
                recv_idle_pct <= 56;
            end
            else if (boxes_sent < 2 * BOX_TARGET / 3)
            begin
                send_idle_pct = 56;
                recv_idle_pct <= 10;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct <= 0;
            end
            load_ray(pick_origin(phase_no % 5 == 0), pick_origin(phase_no % 5 == 0),
                     pick_origin(phase_no % 5 == 0), pick_dir(phase_no % 4),
                     pick_dir(phase_no % 4), pick_dir(phase_no % 4));
            if (!pressed && send_idle_pct == 0)
            begin
                pressed = 1'b1;
                fork
                    begin
                        rx_stall <= 1'b1;
                        repeat (HOLD_CYCLES) @(posedge clk);
                        rx_stall <= 1'b0;
                    end
                join_none
            end
            phase_count = 0;
            while (phase_count < PHASE_BOXES)
            begin
                if ($urandom_range(99) < 5 || phase_count == 0 && phase_no == 1)
                begin
                    n = $urandom_range(BOX_LIMIT + 1, BOX_LIMIT + 10);
                    long_picks++;
                end
                else
                    n = $urandom_range(1, 12);
                for (int k = 0; k < n; k++)
                begin
                    b      = random_box(prev);
                    b.last = (k == n - 1);
                    send_box(b);
                    prev   = b;
                    phase_count++;
                end
            end
            wait_picks_done();
            phase_no++;
        end

        $display("%0d boxes in %0d picks (%0d hits), %0d ray settings",
                 boxes_sent, sb.picks_checked, sb.hits_checked, ray_settings);
        $display("%0d picks past the box limit, one receiver hold-off of %0d cycles",
                 long_picks, HOLD_CYCLES);
        if (sb.errors == 0 && sb.pending_picks.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #(RUN_LIMIT);
        $display("timeout with %0d picks outstanding", sb.pending_picks.size());
        $display("simulation failed");
        $finish;
    end

endmodule
